// ----- rtl/tmte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text-mode terminal engine package
// Screen geometry, field codes and the screen memory request type shared by
// the engine and its screen store.
// ----------------------------------------------------------------------------
package tmte_pkg;

	localparam int unsigned COLUMNS = 80;
	localparam int unsigned ROWS    = 25;
	localparam int unsigned CELLS   = COLUMNS * ROWS;

	localparam int unsigned COL_W   = $clog2(COLUMNS);
	localparam int unsigned ROW_W   = $clog2(ROWS);
	localparam int unsigned ADDR_W  = $clog2(CELLS);

	localparam int unsigned CUR_IDX_W = 11;
	localparam int unsigned CELL_W    = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h0A;

	typedef enum logic [1:0] {
		K_PUT   = 2'd0,
		K_SET   = 2'd1,
		K_CLEAR = 2'd2,
		K_READ  = 2'd3
	} kind_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tmte_screen.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Screen cell store
// One write port and one read port with registered read data, holding the
// attribute and character of every cell.
// ----------------------------------------------------------------------------
module tmte_screen (
	input  wire logic                         clk,
	input  wire tmte_pkg::mem_req_t           req,
	output logic [tmte_pkg::CELL_W-1:0]       rdata
);

	logic [tmte_pkg::CELL_W-1:0] mem [tmte_pkg::CELLS];
	logic [tmte_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/text_mode_terminal_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text-mode terminal engine
// A character console with a cursor: put, set cursor, clear and read items,
// one result beat per item reporting the cursor index.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the screen store once, one cell per cycle, so
// s_tready stays low until every cell is written; configuration writes are taken
// during that time. Put, set-cursor and read items pass through ST_DONE, which
// also waits for the result beat to be taken. A put that wraps or a newline on
// the last row scrolls the screen through the single address counter: a copy
// of each row up by one, a drain of the last copy write, then a blanking of the
// bottom row. A clear walks all CELLS cells.
// ----------------------------------------------------------------------------
module text_mode_terminal_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // char_code, pos_x, pos_y
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // cursor_index, cell_value, zero fill
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	typedef enum logic [4:0] {
		ST_INIT   = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCROLL = 5'b00100,
		ST_FILL   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	localparam logic [tmte_pkg::ADDR_W-1:0] LAST_CELL =
		tmte_pkg::ADDR_W'(tmte_pkg::CELLS - 1);
	localparam logic [tmte_pkg::ADDR_W-1:0] SCROLL_LAST =
		tmte_pkg::ADDR_W'((tmte_pkg::ROWS - 1) * tmte_pkg::COLUMNS - 1);
	localparam logic [tmte_pkg::ADDR_W-1:0] BOTTOM_ROW =
		tmte_pkg::ADDR_W'((tmte_pkg::ROWS - 1) * tmte_pkg::COLUMNS);

	state_t                          state_q;
	logic [tmte_pkg::ADDR_W-1:0]     cnt_q;
	logic [tmte_pkg::ROW_W-1:0]      row_q;
	logic [tmte_pkg::COL_W-1:0]      col_q;
	logic [7:0]                      color_q;
	logic                            read_ok_q;
	logic                            pend_s1;
	logic [tmte_pkg::ADDR_W-1:0]     pend_addr_s1;
	logic                            out_valid_q;
	logic [26:0]                     out_data_q;

	tmte_pkg::mem_req_t              mem_req;
	logic [tmte_pkg::CELL_W-1:0]     mem_rdata;

	tmte_pkg::kind_t                 kind;
	logic [7:0]                      ch;
	logic [7:0]                      px;
	logic [7:0]                      py;
	logic                            accept;
	logic                            px_ok;
	logic                            py_ok;
	logic                            is_nl;
	logic                            last_col;
	logic                            last_row;
	logic                            out_free;
	logic [tmte_pkg::ADDR_W-1:0]     cur_addr;

	assign kind     = tmte_pkg::kind_t'(s_tuser);
	assign ch       = s_tdata[7:0];
	assign px       = s_tdata[15:8];
	assign py       = s_tdata[23:16];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign px_ok    = ({1'b0, px} < 9'(tmte_pkg::COLUMNS));
	assign py_ok    = ({1'b0, py} < 9'(tmte_pkg::ROWS));
	assign is_nl    = (ch == tmte_pkg::NEWLINE_CODE);
	assign last_col = (col_q == tmte_pkg::COL_W'(tmte_pkg::COLUMNS - 1));
	assign last_row = (row_q == tmte_pkg::ROW_W'(tmte_pkg::ROWS - 1));
	assign out_free = !out_valid_q || m_tready;
	assign cur_addr = tmte_pkg::cell_addr(row_q, col_q);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {5'd0, out_data_q};

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q;
				mem_req.wdata = {tmte_pkg::RESET_COLOR, tmte_pkg::SPACE_CODE};
			end
			ST_IDLE: begin
				if (accept && kind == tmte_pkg::K_PUT && !is_nl) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_addr;
					mem_req.wdata = {color_q, ch};
				end
				if (accept && kind == tmte_pkg::K_READ && px_ok && py_ok) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = tmte_pkg::cell_addr(py[tmte_pkg::ROW_W-1:0],
						px[tmte_pkg::COL_W-1:0]);
				end
			end
			ST_SCROLL: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = cnt_q + tmte_pkg::ADDR_W'(tmte_pkg::COLUMNS);
			end
			ST_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q;
				mem_req.wdata = {color_q, tmte_pkg::SPACE_CODE};
			end
			ST_DONE: begin
				mem_req.we = 1'b0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
		if (pend_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = pend_addr_s1;
			mem_req.wdata = mem_rdata;
		end
	end

	tmte_screen u_screen (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tmte_pkg::RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cnt_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			read_ok_q <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						read_ok_q <= (kind == tmte_pkg::K_READ) && px_ok && py_ok;
						unique case (kind)
							tmte_pkg::K_PUT: begin
								if (is_nl || last_col) begin
									col_q <= '0;
									if (last_row) begin
										cnt_q   <= '0;
										state_q <= ST_SCROLL;
									end else begin
										row_q   <= row_q + 1'b1;
										state_q <= ST_DONE;
									end
								end else begin
									col_q   <= col_q + 1'b1;
									state_q <= ST_DONE;
								end
							end
							tmte_pkg::K_SET: begin
								if (px_ok) begin
									col_q <= px[tmte_pkg::COL_W-1:0];
								end
								if (py_ok) begin
									row_q <= py[tmte_pkg::ROW_W-1:0];
								end
								state_q <= ST_DONE;
							end
							tmte_pkg::K_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							tmte_pkg::K_READ: begin
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					if (cnt_q == SCROLL_LAST) begin
						cnt_q   <= BOTTOM_ROW;
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (!pend_s1) begin
						if (cnt_q == LAST_CELL) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCROLL) begin
			pend_addr_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {(read_ok_q ? mem_rdata : 16'd0),
				tmte_pkg::CUR_IDX_W'(cur_addr)};
		end
	end

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < tmte_pkg::ROWS) && (32'(col_q) < tmte_pkg::COLUMNS))
		else $error("cursor left the screen");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in progress");

	a_copy_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCROLL || state_q == ST_FILL))
		else $error("scroll copy write outside a scroll");

	a_no_copy_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && cnt_q == LAST_CELL) |-> !pend_s1)
		else $error("scroll copy still pending at the end of the blanking sweep");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Text-mode terminal engine testbench
// Drives put, set-cursor, clear and read items into the engine. A mirror of
// the screen, the cursor and the text attribute predicts every result beat,
// and each beat is checked against the oldest prediction. A short directed
// run covers wraps, scrolls, out-of-range cursors and reads, and clear. Random
// bursts of text, cursor moves, reads and clears follow under three attribute
// settings and three patterns of stalls.
// ----------------------------------------------------------------------------
module testbench;
	import tmte_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 8_000_000;
	localparam int unsigned SETTLE_CYCLES = 2100;

	typedef struct {
		logic [10:0] cursor_index;
		logic [15:0] cell_value;
	} console_reply_t;

	class console_mirror;
		logic [15:0]    cells [CELLS];
		int unsigned    cur_row;
		int unsigned    cur_col;
		logic [7:0]     attr;
		console_reply_t replies_due [$];
		int unsigned    mismatches;

		function new();
			foreach (cells[i]) cells[i] = {RESET_COLOR, SPACE_CODE};
			cur_row = 0;
			cur_col = 0;
			attr = RESET_COLOR;
			mismatches = 0;
		endfunction

		function void set_attr(logic [7:0] value);
			attr = value;
		endfunction

		function void advance_row();
			cur_row++;
			if (cur_row >= ROWS) begin
				cur_row = ROWS - 1;
				for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
				for (int x = 0; x < COLUMNS; x++) cells[(ROWS - 1) * COLUMNS + x] = {attr, SPACE_CODE};
			end
		endfunction

		function void note_item(kind_t kind, logic [7:0] ch, logic [7:0] px, logic [7:0] py);
			console_reply_t reply;
			reply.cell_value = 16'h0000;
			case (kind)
				K_PUT: begin
					if (ch == NEWLINE_CODE) begin
						advance_row();
						cur_col = 0;
					end else begin
						cells[cur_row * COLUMNS + cur_col] = {attr, ch};
						cur_col++;
						if (cur_col >= COLUMNS) begin
							cur_col = 0;
							advance_row();
						end
					end
				end
				K_SET: begin
					if (px < COLUMNS) cur_col = 32'(px);
					if (py < ROWS) cur_row = 32'(py);
				end
				K_CLEAR: begin
					foreach (cells[i]) cells[i] = {attr, SPACE_CODE};
					cur_row = 0;
					cur_col = 0;
				end
				K_READ: begin
					if (px < COLUMNS && py < ROWS) reply.cell_value = cells[py * COLUMNS + px];
				end
			endcase
			reply.cursor_index = 11'(cur_row * COLUMNS + cur_col);
			replies_due.push_back(reply);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
		endfunction

		function void check_reply(logic [31:0] beat);
			console_reply_t want;
			if (replies_due.size() == 0) begin
				flag("unexpected result beat", 32'h0, beat);
				return;
			end
			want = replies_due.pop_front();
			if (beat[10:0] !== want.cursor_index)
				flag("cursor_index", 32'(want.cursor_index), 32'(beat[10:0]));
			if (beat[26:11] !== want.cell_value)
				flag("cell_value", 32'(want.cell_value), 32'(beat[26:11]));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	console_mirror mirror;
	int unsigned   sender_idle_pct;
	int unsigned   receiver_stall_pct;
	int unsigned   items_sent;
	int unsigned   cycle_count;

	text_mode_terminal_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) mirror.note_item(kind_t'(s_tuser), s_tdata[7:0],
				s_tdata[15:8], s_tdata[23:16]);
			if (m_tvalid && m_tready) mirror.check_reply(m_tdata);
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic push_item(input kind_t kind, input logic [7:0] ch, input logic [7:0] px,
		input logic [7:0] py);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {py, px, ch};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (mirror.replies_due.size() != 0) @(negedge clk);
	endtask

	// A result beat leaves only after its scroll or clear has finished, so the
	// engine is idle once every beat is back and the attribute can change.
	task automatic change_color(input logic [7:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		mirror.set_attr(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_coord(int unsigned bound, int unsigned in_pct);
		if ($urandom_range(99) < in_pct) return 8'($urandom_range(bound - 1));
		return 8'($urandom_range(255));
	endfunction

	task automatic put_text(input int unsigned len);
		logic [7:0] ch;
		for (int i = 0; i < len; i++) begin
			ch = ($urandom_range(99) < 12) ? NEWLINE_CODE : 8'($urandom_range(255));
			push_item(K_PUT, ch, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		target = items_sent + count;
		drain();
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				push_item(K_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
			end else if (pick < 5) begin
				drain();
			end else if (pick < 42) begin
				put_text($urandom_range(40, 5));
			end else if (pick < 62) begin
				push_item(K_SET, 8'($urandom_range(255)), 8'($urandom_range(COLUMNS - 1, 60)),
					8'(ROWS - 1));
				put_text($urandom_range(30, 3));
			end else if (pick < 80) begin
				repeat ($urandom_range(8, 1))
					push_item(K_READ, 8'($urandom_range(255)), pick_coord(COLUMNS, 85),
						pick_coord(ROWS, 85));
			end else begin
				repeat ($urandom_range(3, 1))
					push_item(K_SET, 8'($urandom_range(255)), pick_coord(COLUMNS, 70),
						pick_coord(ROWS, 70));
			end
		end
	endtask

	initial begin
		mirror = new();
		items_sent = 0;
		cycle_count = 0;
		sender_idle_pct = 25;
		receiver_stall_pct = 81;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(K_READ, 8'h00, 8'd0, 8'd0);
		push_item(K_PUT, 8'h41, 8'hFF, 8'hFF);
		push_item(K_PUT, 8'h00, 8'h00, 8'h00);
		push_item(K_PUT, 8'hFF, 8'h00, 8'h00);
		push_item(K_PUT, NEWLINE_CODE, 8'h00, 8'h00);
		push_item(K_READ, 8'h00, 8'd0, 8'd0);
		push_item(K_SET, 8'h00, 8'(COLUMNS - 1), 8'd0);
		push_item(K_PUT, 8'h71, 8'h00, 8'h00);
		push_item(K_SET, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
		push_item(K_PUT, 8'h5A, 8'h00, 8'h00);
		push_item(K_READ, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 2));
		push_item(K_SET, 8'h00, 8'd40, 8'(ROWS - 1));
		push_item(K_PUT, NEWLINE_CODE, 8'h00, 8'h00);
		push_item(K_SET, 8'h00, 8'(COLUMNS), 8'd3);
		push_item(K_SET, 8'h00, 8'd5, 8'(ROWS));
		push_item(K_SET, 8'hFF, 8'hFF, 8'hFF);
		push_item(K_READ, 8'h00, 8'(COLUMNS), 8'd0);
		push_item(K_READ, 8'h00, 8'd0, 8'(ROWS));
		push_item(K_READ, 8'hFF, 8'hFF, 8'hFF);
		push_item(K_READ, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
		push_item(K_CLEAR, 8'h00, 8'h00, 8'h00);
		push_item(K_READ, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 2));

		change_color(8'h00);
		run_random(370);

		sender_idle_pct = 81;
		receiver_stall_pct = 25;
		change_color(8'hFF);
		run_random(370);

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		change_color(8'($urandom_range(254, 1)));
		run_random(360);

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mirror.replies_due.size() != 0)
			mirror.flag("results still outstanding", 32'h0, mirror.replies_due.size());
		if (mirror.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
